// ===== hw/rtl/cto_pkg.sv =====
// Shared types, codes and sizes of the connection timeout table.
package cto_pkg;

   localparam int unsigned CONNECTIONS = 8;
   localparam int unsigned TIMER_TYPES = 4;
   localparam int unsigned SLOTS       = CONNECTIONS * TIMER_TYPES;
   localparam int unsigned CONN_W      = 3;
   localparam int unsigned TYPE_W      = 2;
   localparam int unsigned SLOT_W      = CONN_W + TYPE_W;
   localparam int unsigned NUM_REGS    = 4;
   localparam int unsigned DL_W        = 33;
   localparam logic [15:0] NOT_CONFIGURED = 16'hFFFF;
   localparam logic [15:0] REMAIN_MAX     = 16'hFFFF;

   typedef enum logic [2:0] {
      FUNC_RESET      = 3'd0,
      FUNC_CANCEL     = 3'd1,
      FUNC_CANCEL_ALL = 3'd2,
      FUNC_CHECK      = 3'd3,
      FUNC_NEAREST    = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      KIND_ACK     = 2'd0,
      KIND_EVENT   = 2'd1,
      KIND_DONE    = 2'd2,
      KIND_NEAREST = 2'd3
   } kind_type;

   typedef struct packed {
      logic     load;
      logic     arm;
      logic     cancel;
      logic     cancel_all;
      logic     scan_start;
      logic     mode_nearest;
      logic     type_clear;
      logic     type_next;
      logic     clear_best;
      logic     emit;
      kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       scan_done;
      logic       found;
      logic       last_type;
      logic       out_free;
   } status_type;

endpackage

// ===== hw/rtl/connection_timeout_table.sv =====
// Top level of the connection timeout table: register port, controller and datapath.
//
//  channel  ports          contents
//  req      req_t*         word: func, conn, timer_type, now_ms
//  rsp      rsp_t*         word: event_conn, event_type, remaining_ms; tuser kind; tlast last
//  csr      csr_p*         expiry lengths of the four timer types
//
// Reset, cancel and cancel all go straight from decode to the acknowledgement. For nearest,
// the deadline memory has one read port, so the scan reads one entry a cycle over all 32
// entries. Check makes a pass over one type's 8 entries, one pass per type plus one more per
// event. Reset is synchronous; no clearing pass runs. A stalled rsp holds the controller at
// its next result; req is taken only between items.
module connection_timeout_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // func[2:0], conn[5:3], timer_type[7:6], now_ms[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // event_conn[2:0], event_type[4:3], remaining_ms[20:5]
   output logic [1:0]  rsp_tuser,   // kind[1:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [cto_pkg::NUM_REGS-1:0][15:0] expiry_ff;
   cto_pkg::cmd_type                   cmd;
   cto_pkg::status_type                status;

   assign csr_pready = 1'b1;
   assign csr_prdata = {16'd0, expiry_ff[csr_paddr[3:2]]};

   always_ff @(posedge clock) begin
      if (reset) begin
         expiry_ff <= {cto_pkg::NUM_REGS{cto_pkg::NOT_CONFIGURED}};
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         expiry_ff[csr_paddr[3:2]] <= csr_pwdata[15:0];
      end
   end

   cto_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   cto_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .expiry     (expiry_ff),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== hw/rtl/cto_ctrl.sv =====
// Controller state machine of the connection timeout table.
module cto_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  cto_pkg::status_type status,
   output cto_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_ACK, ST_CSCAN, ST_CEMIT, ST_CDONE, ST_NSCAN, ST_NEMIT
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = cto_pkg::KIND_ACK;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.func)
               cto_pkg::FUNC_RESET: begin
                  cmd.arm  = 1'b1;
                  state_in = ST_ACK;
               end
               cto_pkg::FUNC_CANCEL: begin
                  cmd.cancel = 1'b1;
                  state_in   = ST_ACK;
               end
               cto_pkg::FUNC_CANCEL_ALL: begin
                  cmd.cancel_all = 1'b1;
                  state_in       = ST_ACK;
               end
               cto_pkg::FUNC_CHECK: begin
                  cmd.type_clear = 1'b1;
                  cmd.scan_start = 1'b1;
                  state_in       = ST_CSCAN;
               end
               cto_pkg::FUNC_NEAREST: begin
                  cmd.scan_start   = 1'b1;
                  cmd.mode_nearest = 1'b1;
                  state_in         = ST_NSCAN;
               end
               default: state_in = ST_ACK;
            endcase
         end
         ST_ACK: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = cto_pkg::KIND_ACK;
               state_in = ST_IDLE;
            end
         end
         ST_CSCAN: begin
            if (status.scan_done) begin
               if (status.found) begin
                  state_in = ST_CEMIT;
               end else if (status.last_type) begin
                  state_in = ST_CDONE;
               end else begin
                  cmd.type_next  = 1'b1;
                  cmd.scan_start = 1'b1;
               end
            end
         end
         ST_CEMIT: begin
            if (status.out_free) begin
               cmd.emit       = 1'b1;
               cmd.kind       = cto_pkg::KIND_EVENT;
               cmd.clear_best = 1'b1;
               cmd.scan_start = 1'b1;
               state_in       = ST_CSCAN;
            end
         end
         ST_CDONE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = cto_pkg::KIND_DONE;
               state_in = ST_IDLE;
            end
         end
         ST_NSCAN: begin
            if (status.scan_done) begin
               state_in = ST_NEMIT;
            end
         end
         ST_NEMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = cto_pkg::KIND_NEAREST;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/cto_datapath.sv =====
// Datapath of the connection timeout table: deadline memory, armed flags, scan, result word.
module cto_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic [39:0]                            req_tdata,
   input  logic [cto_pkg::NUM_REGS-1:0][15:0]     expiry,
   input  cto_pkg::cmd_type                       cmd,
   output cto_pkg::status_type                    status,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [23:0]                            rsp_tdata,
   output logic [1:0]                             rsp_tuser,
   output logic                                   rsp_tlast
);

   logic [2:0]                  func_ff;
   logic [cto_pkg::CONN_W-1:0]  conn_ff;
   logic [cto_pkg::TYPE_W-1:0]  type_ff;
   logic [31:0]                 now_ff;

   logic [cto_pkg::DL_W-1:0]    deadline [cto_pkg::SLOTS];
   logic [cto_pkg::DL_W-1:0]    rd_data_ff;
   logic [cto_pkg::SLOTS-1:0]   armed_ff;
   logic [cto_pkg::SLOTS-1:0]   armed_in;

   logic                        mode_nearest_ff;
   logic                        scan_go_ff;
   logic [cto_pkg::SLOT_W-1:0]  idx_ff;
   logic [cto_pkg::TYPE_W-1:0]  typ_ff;
   logic                        cmp_valid_ff;
   logic                        cmp_last_ff;
   logic [cto_pkg::SLOT_W-1:0]  cmp_slot_ff;
   logic                        done_ff;
   logic                        found_ff;
   logic [cto_pkg::DL_W-1:0]    best_dl_ff;
   logic [cto_pkg::CONN_W-1:0]  best_conn_ff;
   logic [15:0]                 best_rem_ff;

   logic                        rsp_valid_ff;
   logic [23:0]                 rsp_data_ff;
   logic [1:0]                  rsp_user_ff;
   logic                        rsp_last_ff;

   logic [cto_pkg::SLOT_W-1:0]  rd_addr;
   logic                        scan_last;
   logic [cto_pkg::DL_W-1:0]    now_ext;
   logic [cto_pkg::DL_W-1:0]    diff;
   logic [15:0]                 rem;
   logic                        cmp_armed;
   logic                        out_free;
   logic [15:0]                 exp_sel;

   assign now_ext   = {1'b0, now_ff};
   assign rd_addr   = mode_nearest_ff ? idx_ff : {idx_ff[cto_pkg::CONN_W-1:0], typ_ff};
   assign scan_last = mode_nearest_ff ? (idx_ff == cto_pkg::SLOT_W'(cto_pkg::SLOTS - 1))
                                      : (idx_ff == cto_pkg::SLOT_W'(cto_pkg::CONNECTIONS - 1));
   assign diff      = rd_data_ff - now_ext;
   assign rem       = (rd_data_ff <= now_ext) ? 16'd0 :
                      (diff > cto_pkg::DL_W'(cto_pkg::REMAIN_MAX)) ? cto_pkg::REMAIN_MAX :
                      diff[15:0];
   assign cmp_armed = armed_ff[cmp_slot_ff];
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign exp_sel   = expiry[type_ff];

   // hold the accepted word
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_tdata[2:0];
         conn_ff <= req_tdata[5:3];
         type_ff <= req_tdata[7:6];
         now_ff  <= req_tdata[39:8];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.arm && exp_sel != cto_pkg::NOT_CONFIGURED) begin
         deadline[{conn_ff, type_ff}] <= now_ext + cto_pkg::DL_W'(exp_sel);
      end
      rd_data_ff <= deadline[rd_addr];
   end

   always_comb begin
      armed_in = armed_ff;
      if (cmd.arm && exp_sel != cto_pkg::NOT_CONFIGURED) begin
         armed_in[{conn_ff, type_ff}] = 1'b1;
      end
      if (cmd.cancel) begin
         armed_in[{conn_ff, type_ff}] = 1'b0;
      end
      if (cmd.cancel_all) begin
         for (int t = 0; t < cto_pkg::TIMER_TYPES; t++) begin
            armed_in[{conn_ff, cto_pkg::TYPE_W'(t)}] = 1'b0;
         end
      end
      if (cmd.clear_best) begin
         armed_in[{best_conn_ff, typ_ff}] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= '0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   // advance the scan, one entry a cycle, compare each entry in the cycle after its read
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_go_ff   <= 1'b0;
         cmp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         cmp_valid_ff <= scan_go_ff;
         done_ff      <= cmp_valid_ff && cmp_last_ff;
         if (cmd.scan_start) begin
            scan_go_ff <= 1'b1;
         end else if (scan_go_ff && scan_last) begin
            scan_go_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmp_slot_ff <= rd_addr;
      cmp_last_ff <= scan_last;
      if (cmd.type_clear) begin
         typ_ff <= '0;
      end else if (cmd.type_next) begin
         typ_ff <= typ_ff + 1'b1;
      end
      if (cmd.scan_start) begin
         idx_ff          <= '0;
         mode_nearest_ff <= cmd.mode_nearest;
         found_ff        <= 1'b0;
         best_rem_ff     <= cto_pkg::REMAIN_MAX;
      end else begin
         if (scan_go_ff && !scan_last) begin
            idx_ff <= idx_ff + 1'b1;
         end
         if (cmp_valid_ff && cmp_armed) begin
            if (mode_nearest_ff) begin
               if (rem < best_rem_ff) begin
                  best_rem_ff <= rem;
               end
            end else if (rd_data_ff <= now_ext && (!found_ff || rd_data_ff < best_dl_ff)) begin
               found_ff     <= 1'b1;
               best_dl_ff   <= rd_data_ff;
               best_conn_ff <= cmp_slot_ff[cto_pkg::SLOT_W-1:cto_pkg::TYPE_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_user_ff <= cmd.kind;
         rsp_last_ff <= (cmd.kind != cto_pkg::KIND_EVENT);
         case (cmd.kind)
            cto_pkg::KIND_EVENT:   rsp_data_ff <= {19'd0, typ_ff, best_conn_ff};
            cto_pkg::KIND_NEAREST: rsp_data_ff <= {3'd0, best_rem_ff, 5'd0};
            default:               rsp_data_ff <= '0;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   assign status.func      = func_ff;
   assign status.scan_done = done_ff;
   assign status.found     = found_ff;
   assign status.last_type = (typ_ff == cto_pkg::TYPE_W'(cto_pkg::TIMER_TYPES - 1));
   assign status.out_free  = out_free;

endmodule

// ===== tb/sv/tb_connection_timeout_table.sv =====
// Testbench of the connection timeout table: directed and random operations against a predictor.
module tb_connection_timeout_table;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      cto_pkg::kind_type kind;
      logic [2:0]        conn;
      logic [1:0]        ttype;
      logic [15:0]       remain;
      logic              last;
   } outcome_type;

   localparam int REG_IDLE = 0;
   localparam int REG_RX   = 1;
   localparam int REG_TX   = 2;
   localparam int REG_DOWN = 3;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [23:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   connection_timeout_table DUT (.*);

   always #5 clock = ~clock;

   logic [15:0] expiry_len [cto_pkg::NUM_REGS];
   logic [32:0] due_at [cto_pkg::SLOTS];
   logic        active [cto_pkg::SLOTS];
   outcome_type pending_results [$];
   int          mismatches = 0;
   bit          calm = 0;
   logic [31:0] clock_ms = 32'd1000;

   function automatic void predict(cto_pkg::func_type f, logic [2:0] c, logic [1:0] t,
                                   logic [31:0] now);
      outcome_type o;
      int          best;
      logic [32:0] bd;
      logic [32:0] rem;
      logic [32:0] least;
      o = '0;
      o.kind = cto_pkg::KIND_ACK;
      o.last = 1;
      case (f)
         cto_pkg::FUNC_RESET: begin
            if (expiry_len[t] != cto_pkg::NOT_CONFIGURED) begin
               due_at[{c, t}] = {1'b0, now} + 33'(expiry_len[t]);
               active[{c, t}] = 1;
            end
         end
         cto_pkg::FUNC_CANCEL: active[{c, t}] = 0;
         cto_pkg::FUNC_CANCEL_ALL: begin
            for (int ty = 0; ty < cto_pkg::TIMER_TYPES; ty++) active[{c, 2'(ty)}] = 0;
         end
         cto_pkg::FUNC_CHECK: begin
            for (int ty = 0; ty < cto_pkg::TIMER_TYPES; ty++) begin
               forever begin
                  best = -1;
                  bd = '0;
                  for (int i = 0; i < cto_pkg::CONNECTIONS; i++)
                     if (active[{3'(i), 2'(ty)}] && due_at[{3'(i), 2'(ty)}] <= {1'b0, now}
                         && (best < 0 || due_at[{3'(i), 2'(ty)}] < bd)) begin
                        best = i;
                        bd = due_at[{3'(i), 2'(ty)}];
                     end
                  if (best < 0) break;
                  active[{3'(best), 2'(ty)}] = 0;
                  pending_results.push_back('{cto_pkg::KIND_EVENT, best[2:0], ty[1:0],
                                              16'd0, 1'b0});
               end
            end
            o.kind = cto_pkg::KIND_DONE;
         end
         cto_pkg::FUNC_NEAREST: begin
            least = 33'(cto_pkg::REMAIN_MAX);
            for (int i = 0; i < cto_pkg::SLOTS; i++)
               if (active[5'(i)]) begin
                  rem = due_at[5'(i)] > {1'b0, now} ? due_at[5'(i)] - {1'b0, now} : '0;
                  if (rem < least) least = rem;
               end
            o.kind = cto_pkg::KIND_NEAREST;
            o.remain = least[15:0];
         end
         default: ;
      endcase
      pending_results.push_back(o);
   endfunction

   task automatic send_word(logic [2:0] f, logic [2:0] c, logic [1:0] t, logic [31:0] now);
      @(posedge clock);
      while (!calm && $urandom_range(99) < 13) @(posedge clock);
      req_tvalid <= 1;
      req_tdata <= {now, t, c, f};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict(cto_pkg::func_type'(f), c, t, now);
      req_tvalid <= 0;
   endtask

   task automatic drain();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(int idx, logic [15:0] v);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= 4'(4 * idx); csr_pwdata <= {16'($urandom_range(65535)), v};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      expiry_len[idx] = v;
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      @(posedge clock);
   endtask

   task automatic set_all(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic [15:0] d);
      drain();
      write_reg(REG_IDLE, a);
      write_reg(REG_RX, b);
      write_reg(REG_TX, c);
      write_reg(REG_DOWN, d);
   endtask

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{cto_pkg::kind_type'(rsp_tuser), rsp_tdata[2:0], rsp_tdata[4:3],
                 rsp_tdata[20:5], rsp_tlast};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("expected %p got %p", want, got);
            end
         end
      end
   end

   always @(posedge clock) rsp_tready <= calm ? 1'b1 : ($urandom_range(99) >= 13);

   task automatic test_unconfigured();
      send_word(cto_pkg::FUNC_RESET, 3'd0, 2'd0, clock_ms);
      send_word(cto_pkg::FUNC_NEAREST, 3'd7, 2'd3, clock_ms);
      send_word(cto_pkg::FUNC_CHECK, 3'd0, 2'd0, 32'hFFFF_FFFF);
      for (int f = 5; f < 8; f++) send_word(f[2:0], 3'd7, 2'd3, 32'hFFFF_FFFF);
   endtask

   task automatic test_directed();
      set_all(16'd0, 16'd100, 16'd65534, 16'd7);
      for (int c = 0; c < 8; c++) send_word(cto_pkg::FUNC_RESET, c[2:0], c[1:0], 32'hFFFF_FF00);
      send_word(cto_pkg::FUNC_RESET, 3'd5, 2'd3, 32'hFFFF_FF00);
      send_word(cto_pkg::FUNC_NEAREST, 3'd0, 2'd0, 32'hFFFF_FF00);
      send_word(cto_pkg::FUNC_NEAREST, 3'd0, 2'd0, 32'd0);
      send_word(cto_pkg::FUNC_CANCEL, 3'd1, 2'd1, 32'd0);
      send_word(cto_pkg::FUNC_CANCEL_ALL, 3'd2, 2'd0, 32'd0);
      send_word(cto_pkg::FUNC_CHECK, 3'd0, 2'd0, 32'hFFFF_FF08);
      send_word(cto_pkg::FUNC_CHECK, 3'd0, 2'd0, 32'hFFFF_FFFF);
      send_word(cto_pkg::FUNC_NEAREST, 3'd0, 2'd0, 32'hFFFF_FFFF);
   endtask

   task automatic test_random(int n);
      logic [2:0] f;
      for (int k = 0; k < n; k++) begin
         calm = (k >= n / 2 && k < n / 2 + 25);
         clock_ms = 32'(clock_ms + $urandom_range(40));
         if ($urandom_range(19) == 0) clock_ms = $urandom;
         case ($urandom_range(9))
            0, 1, 2, 3: f = cto_pkg::FUNC_RESET;
            4: f = cto_pkg::FUNC_CANCEL;
            5: f = cto_pkg::FUNC_CANCEL_ALL;
            6, 7: f = cto_pkg::FUNC_CHECK;
            8: f = cto_pkg::FUNC_NEAREST;
            default: f = 3'($urandom_range(7));
         endcase
         send_word(f, 3'($urandom_range(7)), 2'($urandom_range(3)), clock_ms);
         if (k == n / 3) drain();
      end
      calm = 0;
   endtask

   initial begin
      for (int i = 0; i < cto_pkg::NUM_REGS; i++) expiry_len[i] = cto_pkg::NOT_CONFIGURED;
      for (int i = 0; i < cto_pkg::SLOTS; i++) active[i] = 0;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_unconfigured();
      test_directed();
      set_all(16'd20, 16'd50, 16'd5, 16'd120);
      test_random(55);
      set_all(16'd65535, 16'd10, 16'd0, 16'd30);
      test_random(50);
      drain();
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("*** FAILED ***");
      $finish;
   end
endmodule

// ===== filelist.f =====
hw/rtl/cto_pkg.sv
hw/rtl/cto_ctrl.sv
hw/rtl/cto_datapath.sv
hw/rtl/connection_timeout_table.sv
tb/sv/tb_connection_timeout_table.sv
